// ----- sv/tga_rle_pkg.sv -----
// shared types, constants and functions of the targa body decoder
// no dependencies

package tga_rle_pkg;

  localparam int MAP_DEPTH = 16384;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int WIN_W     = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_USE_MAP    = 3'd0;
  localparam cfg_index_t REG_RLE        = 3'd1;
  localparam cfg_index_t REG_PIX_FMT    = 3'd2;
  localparam cfg_index_t REG_MAP_FMT    = 3'd3;
  localparam cfg_index_t REG_MAP_FIRST  = 3'd4;
  localparam cfg_index_t REG_MAP_COUNT  = 3'd5;

  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_24 = 2'd2;
  localparam logic [1:0] FMT_32 = 2'd3;

  // one queue entry: either a map store or a pixel result
  typedef struct packed {
    logic              is_write;
    logic [MAP_AW-1:0] addr;
    logic [23:0]       rgb;
    logic [7:0]        rep;
    logic              lookup;
    logic              err;
  } item_t;

  // colour as {red, green, blue} from up to three gathered bytes
  function automatic logic [23:0] colour_of(input logic [23:0] g, input logic [1:0] fmt);
    logic [7:0] b0, b1, b2, r, gr, bl;
    b0 = g[7:0];
    b1 = g[15:8];
    b2 = g[23:16];
    case (fmt)
      FMT_8: begin
        r  = b0;
        gr = b0;
        bl = b0;
      end
      FMT_16: begin
        r  = {3'd0, b1[6:2]};
        gr = {3'd0, b1[1:0], b0[7:5]};
        bl = {3'd0, b0[4:0]};
      end
      default: begin
        r  = b2;
        gr = b1;
        bl = b0;
      end
    endcase
    return {r, gr, bl};
  endfunction

endpackage

// ----- sv/tga_rle_pixel_decoder.sv -----
// top level of the targa image body decoder
// depends on tga_rle_pkg, tga_rle_front, tga_rle_queue, tga_rle_back

// usage
//   input channel: one body byte per request on data_byte (in_valid / in_stall);
//   colour-map entries come first, then pixel data with optional packet headers
//   output channel: one request per pixel or per repeated run (out_valid / out_stall)
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high; write only while idle, every write restarts the image
// throughput: one byte per cycle sustained while in_stall is low; header, map and partial bytes give
//   no result, map entries are stored into the colour-map memory by the back end
// output path: the byte that completes a pixel writes it into the queue, from which
//   it is popped into the output register; the colour-map memory read is the registered step
// stall: a four-entry queue parts front and back; in_stall rises only when it is
//   full, and map stores keep draining while the output is stalled
// reset: formats default to 24-bit, no map, no packets; queue and output empty;
//   the colour-map memory is not cleared and is valid only once loaded

module tga_rle_pixel_decoder import tga_rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  repeat_count,
  output logic        index_error
);

  logic  byte_take;
  logic  push, pop, full, not_empty;
  item_t push_item, head;

  assign cfg_ready = 1'b1;
  // queue full holds the source back
  assign in_stall  = full;
  assign byte_take = in_valid && !in_stall;

  tga_rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_take (byte_take),
    .data_byte (data_byte),
    .push      (push),
    .push_item (push_item)
  );

  tga_rle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  tga_rle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .repeat_count (repeat_count),
    .index_error  (index_error)
  );

endmodule

// ----- sv/tga_rle_front.sv -----
// front end: configuration registers, byte gathering, packet headers, classification
// depends on tga_rle_pkg

module tga_rle_front import tga_rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  cfg_index_t  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        byte_take,
  input  logic [7:0]  data_byte,
  output logic        push,
  output item_t       push_item
);

  logic        use_map, rle;
  logic [1:0]  pix_fmt, map_fmt;
  logic [13:0] map_first, map_count;

  logic        loading;
  logic [13:0] map_pos;
  logic [1:0]  bie;
  logic [23:0] gathered;
  logic [7:0]  run_rem;
  logic        run_rep;

  logic [1:0]        fmt;
  logic [23:0]       elem;
  logic              complete;
  logic [13:0]       map_pos_next;
  logic [WIN_W-1:0]  wr_addr;
  logic [15:0]       idx;
  logic              in_win;
  logic [13:0]       count_next;

  assign fmt      = loading ? map_fmt : pix_fmt;
  assign complete = (bie >= fmt);
  assign map_pos_next = map_pos + 14'd1;
  assign wr_addr  = WIN_W'(map_first) + WIN_W'(map_pos);
  assign count_next = (cfg_index == REG_MAP_COUNT) ? cfg_data : map_count;

  always_comb begin
    elem = gathered;
    case (bie)
      2'd0:    elem[7:0]   = data_byte;
      2'd1:    elem[15:8]  = data_byte;
      2'd2:    elem[23:16] = data_byte;
      default: elem = gathered;
    endcase
  end

  always_comb begin
    case (pix_fmt)
      FMT_8:   idx = {8'd0, elem[7:0]};
      FMT_16:  idx = elem[15:0];
      default: idx = 16'd0;
    endcase
  end

  assign in_win = (WIN_W'(idx) >= WIN_W'(map_first))
               && (WIN_W'(idx) < WIN_W'(map_first) + WIN_W'(map_count))
               && (WIN_W'(idx) < WIN_W'(MAP_DEPTH));

  // classification of the byte being taken
  always_comb begin
    push           = 1'b0;
    push_item      = '0;
    if (byte_take && complete) begin
      if (loading) begin
        push               = (wr_addr < WIN_W'(MAP_DEPTH));
        push_item.is_write = 1'b1;
        push_item.addr     = wr_addr[MAP_AW-1:0];
        push_item.rgb      = colour_of(elem, map_fmt);
      end else if (!(rle && run_rem == 8'd0)) begin
        push               = 1'b1;
        push_item.addr     = idx[MAP_AW-1:0];
        push_item.rep      = (rle && run_rep) ? run_rem : 8'd1;
        if (use_map) begin
          push_item.lookup = in_win;
          push_item.err    = !in_win;
          push_item.rgb    = 24'd0;
        end else begin
          push_item.rgb    = colour_of(elem, pix_fmt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_map   <= 1'b0;
      rle       <= 1'b0;
      pix_fmt   <= FMT_24;
      map_fmt   <= FMT_24;
      map_first <= '0;
      map_count <= '0;
      loading   <= 1'b0;
      map_pos   <= '0;
      bie       <= '0;
      gathered  <= '0;
      run_rem   <= '0;
      run_rep   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_USE_MAP:   use_map   <= cfg_data[0];
        REG_RLE:       rle       <= cfg_data[0];
        REG_PIX_FMT:   pix_fmt   <= cfg_data[1:0];
        REG_MAP_FMT:   map_fmt   <= cfg_data[1:0];
        REG_MAP_FIRST: map_first <= cfg_data;
        REG_MAP_COUNT: map_count <= cfg_data;
        default: ;
      endcase
      // any write restarts the image
      loading  <= (count_next != 14'd0);
      map_pos  <= '0;
      bie      <= '0;
      gathered <= '0;
      run_rem  <= '0;
      run_rep  <= 1'b0;
    end else if (byte_take) begin
      if (loading) begin
        if (complete) begin
          bie      <= '0;
          gathered <= '0;
          map_pos  <= map_pos_next;
          if (map_pos_next >= map_count) begin
            loading <= 1'b0;
          end
        end else begin
          bie      <= bie + 2'd1;
          gathered <= elem;
        end
      end else if (rle && run_rem == 8'd0) begin
        run_rep <= data_byte[7];
        run_rem <= {1'b0, data_byte[6:0]} + 8'd1;
      end else if (complete) begin
        bie      <= '0;
        gathered <= '0;
        if (rle) begin
          if (run_rep) begin
            run_rem <= '0;
          end else begin
            run_rem <= run_rem - 8'd1;
          end
        end
      end else begin
        bie      <= bie + 2'd1;
        gathered <= elem;
      end
    end
  end

endmodule

// ----- sv/tga_rle_queue.sv -----
// short queue of classified items between front end and back end
// depends on tga_rle_pkg

module tga_rle_queue import tga_rle_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  item_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/tga_rle_back.sv -----
// back end: colour-map memory, map stores, lookups and the output register
// depends on tga_rle_pkg

module tga_rle_back import tga_rle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       not_empty,
  input  item_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] repeat_count,
  output logic       index_error
);

  logic [23:0] color_mem [MAP_DEPTH];
  logic [23:0] rd_rgb;
  logic [23:0] rgb_q;
  logic [7:0]  rep_q;
  logic        err_q, lookup_q;
  logic        out_free;
  logic        load;
  logic [23:0] rgb_out;

  assign out_free = !out_valid || !out_stall;
  // stores never wait on the output side
  assign pop  = not_empty && (head.is_write || out_free);
  assign load = pop && !head.is_write;

  always_ff @(posedge clk) begin
    if (pop && head.is_write) begin
      color_mem[head.addr] <= head.rgb;
    end
    if (load) begin
      rd_rgb <= color_mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_q    <= head.rgb;
      rep_q    <= head.rep;
      err_q    <= head.err;
      lookup_q <= head.lookup;
    end
  end

  assign rgb_out      = lookup_q ? rd_rgb : rgb_q;
  assign red          = rgb_out[23:16];
  assign green        = rgb_out[15:8];
  assign blue         = rgb_out[7:0];
  assign repeat_count = rep_q;
  assign index_error  = err_q;

endmodule
